FILE: rtl/text_line_number_visible_filter_core_defines.svh
// Assertion macros shared by the checker of the text line filter core.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef TEXT_LINE_NUMBER_VISIBLE_FILTER_CORE_DEFINES_SVH
`define TEXT_LINE_NUMBER_VISIBLE_FILTER_CORE_DEFINES_SVH

// Checks that the consequent holds in the cycle after the antecedent, outside reset.
`define TLNVF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Checks the cycle after reset is sampled high; active during reset as well.
`define TLNVF_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/tlnvf_pkg.sv
// Package for the text line filter core: types, character codes and defaults.
// Depends on nothing; imported by every module of the core.
`default_nettype none

package tlnvf_pkg;

   // Default line number width in decimal places.
   localparam int DefNumberDigits = 6;
   // Largest line count that the 20-bit counter state can hold.
   localparam longint unsigned CountCap = 64'd1048575;

   // Longest rendered body of one byte, as in M-^?.
   localparam int MaxBody = 4;
   localparam int BodyIdxW = $clog2(MaxBody);
   localparam int BodyLenW = $clog2(MaxBody + 1);

   // Depth of the descriptor queue between front and back.
   localparam int QueueDepth = 4;

   // Character codes.
   localparam logic [7:0] AsciiTab = 8'h09;
   localparam logic [7:0] AsciiNewline = 8'h0a;
   localparam logic [7:0] AsciiSpace = 8'h20;
   localparam logic [7:0] AsciiDollar = 8'h24;
   localparam logic [7:0] AsciiDash = 8'h2d;
   localparam logic [7:0] AsciiZero = 8'h30;
   localparam logic [7:0] AsciiUpperI = 8'h49;
   localparam logic [7:0] AsciiUpperM = 8'h4d;
   localparam logic [7:0] AsciiCaret = 8'h5e;
   localparam logic [6:0] CtrlLimit = 7'h20;
   localparam logic [6:0] DelCode = 7'h7f;
   localparam logic [7:0] DelShown = 8'h3f;
   localparam logic [7:0] CaretOffset = 8'h40;

   // Line numbering modes.
   localparam logic [1:0] NumModeNone = 2'd0;
   localparam logic [1:0] NumModeAll = 2'd1;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CsrNumberMode = 3'd0,
      CsrShowTabs = 3'd1,
      CsrShowEnds = 3'd2,
      CsrSqueezeBlank = 3'd3,
      CsrShowNonprinting = 3'd4
   } csr_index_type;

   localparam int CsrDataW = 2;

   // Configuration register set.
   typedef struct packed {
      logic [1:0] number_mode;
      logic tab_caret;
      logic end_dollar;
      logic squeeze_blank;
      logic show_nonprinting;
   } cfg_type;

   // Classified item: line number request and the rendered body bytes.
   typedef struct packed {
      logic num_en;
      logic [BodyLenW-1:0] body_len;
      logic [MaxBody-1:0][7:0] body_bytes;
   } body_type;

endpackage

`default_nettype wire

FILE: rtl/tlnvf_queue.sv
// Small register queue carrying classified items from front to back.
// Depends on tlnvf_pkg for the default depth.
`default_nettype none

module tlnvf_queue #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH = tlnvf_pkg::QueueDepth
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire logic [DATA_WIDTH-1:0] push_data,
   output logic full,
   input wire logic pop,
   output logic head_valid,
   output logic [DATA_WIDTH-1:0] head_data
);
   import tlnvf_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DATA_WIDTH-1:0] entries_ff [DEPTH];
   logic [PtrW:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW:0] rd_ptr_ff, rd_ptr_in;

   // Full when the pointers differ only in the wrap bit.
   assign full = (wr_ptr_ff[PtrW] != rd_ptr_ff[PtrW])
              && (wr_ptr_ff[PtrW-1:0] == rd_ptr_ff[PtrW-1:0]);
   assign head_valid = (wr_ptr_ff != rd_ptr_ff);
   assign head_data = entries_ff[rd_ptr_ff[PtrW-1:0]];

   // Pointer advance on each transfer in and out.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop && head_valid) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push && !full) begin
         entries_ff[wr_ptr_ff[PtrW-1:0]] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tlnvf_front.sv
// Front end: accepts input bytes, tracks line state and the decimal line
// counter, and classifies each byte into a body descriptor. Uses tlnvf_pkg.
`default_nettype none

module tlnvf_front #(
   parameter int NUMBER_DIGITS = tlnvf_pkg::DefNumberDigits
) (
   input wire logic clock,
   input wire logic reset,
   input wire tlnvf_pkg::cfg_type cfg,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [7:0] req_in_byte,
   input wire logic queue_full,
   output logic push,
   output tlnvf_pkg::body_type push_body,
   output logic [4*NUMBER_DIGITS-1:0] push_digits
);
   import tlnvf_pkg::*;

   localparam int DigitsW = 4 * NUMBER_DIGITS;
   // Saturation point of the counter: all nines, or the 20-bit cap if lower.
   localparam longint unsigned CountLimit = (NUMBER_DIGITS >= 7) ? CountCap
      : ((64'd10 ** NUMBER_DIGITS) - 64'd1);

   logic at_line_start_ff, at_line_start_in;
   logic blank_seen_ff, blank_seen_in;
   logic [DigitsW-1:0] count_ff, count_in;

   logic [DigitsW-1:0] limit_digits;
   logic [DigitsW-1:0] count_inc;
   logic [DigitsW-1:0] count_next;
   logic at_limit;
   logic accept;
   logic nl;
   logic is_tab;
   logic drop;
   logic num_en;
   logic hi_bit;
   logic [6:0] low7;
   logic ctrl;
   logic caret;
   logic [7:0] vis_char;
   logic [BodyLenW-1:0] fill;
   logic [MaxBody-1:0][7:0] bytes;

   // Counter limit in BCD, one constant digit per place.
   for (genvar gi = 0; gi < NUMBER_DIGITS; gi++) begin : g_limit
      localparam logic [3:0] LimDigit = 4'((CountLimit / (64'd10 ** gi)) % 64'd10);
      assign limit_digits[4*gi +: 4] = LimDigit;
   end

   // Decimal increment: a place steps up, nine wrapping to zero, when all places below it are nine.
   always_comb begin
      logic carry;
      carry = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (carry) begin
            count_inc[4*i +: 4] = (count_ff[4*i +: 4] == 4'd9) ? 4'd0
               : count_ff[4*i +: 4] + 4'd1;
         end else begin
            count_inc[4*i +: 4] = count_ff[4*i +: 4];
         end
         carry = carry && (count_ff[4*i +: 4] == 4'd9);
      end
   end

   assign at_limit = (count_ff == limit_digits);
   assign count_next = at_limit ? count_ff : count_inc;

   // Input handshake: the queue decides.
   assign req_ready = !queue_full;
   assign accept = req_valid && req_ready;

   // Line start decisions.
   assign nl = (req_in_byte == AsciiNewline);
   assign is_tab = (req_in_byte == AsciiTab);
   assign drop = at_line_start_ff && cfg.squeeze_blank && nl && blank_seen_ff;
   assign num_en = at_line_start_ff && (cfg.number_mode != NumModeNone)
                && ((cfg.number_mode == NumModeAll) || !nl);
   assign push = accept && !drop;

   // Visible form of one byte: M- prefix for high bytes, caret for controls.
   assign hi_bit = req_in_byte[7];
   assign low7 = req_in_byte[6:0];
   assign ctrl = (low7 < CtrlLimit) || (low7 == DelCode);
   assign caret = ctrl && (hi_bit || ((low7 != AsciiTab[6:0]) && (low7 != AsciiNewline[6:0])));
   always_comb begin
      if (!caret) begin
         vis_char = {1'b0, low7};
      end else if (low7 == DelCode) begin
         vis_char = DelShown;
      end else begin
         vis_char = {1'b0, low7} + CaretOffset;
      end
   end

   // Pack the rendered body bytes in output order.
   always_comb begin
      fill = '0;
      bytes = '0;
      if (is_tab && cfg.tab_caret) begin
         bytes[0] = AsciiCaret;
         bytes[1] = AsciiUpperI;
         fill = BodyLenW'(2);
      end else begin
         if (nl && cfg.end_dollar) begin
            bytes[fill[BodyIdxW-1:0]] = AsciiDollar;
            fill = fill + 1'b1;
         end
         if (cfg.show_nonprinting) begin
            if (hi_bit) begin
               bytes[fill[BodyIdxW-1:0]] = AsciiUpperM;
               fill = fill + 1'b1;
               bytes[fill[BodyIdxW-1:0]] = AsciiDash;
               fill = fill + 1'b1;
            end
            if (caret) begin
               bytes[fill[BodyIdxW-1:0]] = AsciiCaret;
               fill = fill + 1'b1;
            end
            bytes[fill[BodyIdxW-1:0]] = vis_char;
            fill = fill + 1'b1;
         end else begin
            bytes[fill[BodyIdxW-1:0]] = req_in_byte;
            fill = fill + 1'b1;
         end
      end
   end

   assign push_body.num_en = num_en;
   assign push_body.body_len = fill;
   assign push_body.body_bytes = bytes;
   assign push_digits = count_next;

   // Line state advances on every kept transfer; a squeezed line leaves it alone.
   always_comb begin
      at_line_start_in = at_line_start_ff;
      blank_seen_in = blank_seen_ff;
      count_in = count_ff;
      if (push) begin
         at_line_start_in = nl;
         if (at_line_start_ff) begin
            blank_seen_in = cfg.squeeze_blank && nl;
         end
         if (num_en) begin
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_line_start_ff <= 1'b1;
         blank_seen_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         at_line_start_ff <= at_line_start_in;
         blank_seen_ff <= blank_seen_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tlnvf_back.sv
// Back end: walks the head descriptor (number places, tab, body) into the output
// register one byte per cycle while the receiver takes them. Uses tlnvf_pkg.
`default_nettype none

module tlnvf_back #(
   parameter int NUMBER_DIGITS = tlnvf_pkg::DefNumberDigits
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic head_valid,
   input wire tlnvf_pkg::body_type head_body,
   input wire logic [4*NUMBER_DIGITS-1:0] head_digits,
   output logic pop,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic rsp_run_end
);
   import tlnvf_pkg::*;

   localparam int SeqW = $clog2(NUMBER_DIGITS + MaxBody + 1);
   localparam logic [SeqW-1:0] TabPos = SeqW'(NUMBER_DIGITS);
   localparam logic [SeqW-1:0] BodyStart = SeqW'(NUMBER_DIGITS + 1);

   logic [SeqW-1:0] seq_ff, seq_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic rsp_run_end_ff;

   logic [SeqW-1:0] pos;
   logic [SeqW-1:0] body_off;
   logic last;
   logic load;
   logic [NUMBER_DIGITS-1:0] lead_blank;
   logic [7:0] digit_char;
   logic [7:0] sel_byte;

   // Position in the full run; an item without a number starts at the body.
   assign pos = seq_ff + (head_body.num_en ? '0 : BodyStart);
   assign body_off = pos - BodyStart;
   assign last = (pos == (TabPos + SeqW'(head_body.body_len)));
   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop = load && last;

   // Leading zeros print as spaces; the units place always shows a digit.
   always_comb begin
      logic run_zero;
      run_zero = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         run_zero = run_zero && (head_digits[4*(NUMBER_DIGITS-1-i) +: 4] == 4'd0);
         lead_blank[i] = run_zero && (i != NUMBER_DIGITS - 1);
      end
   end

   // Character of the number place at the current position.
   always_comb begin
      digit_char = AsciiSpace;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (pos == SeqW'(i)) begin
            digit_char = lead_blank[i] ? AsciiSpace
               : (AsciiZero | {4'd0, head_digits[4*(NUMBER_DIGITS-1-i) +: 4]});
         end
      end
   end

   // Byte select for the current position.
   always_comb begin
      if (pos < TabPos) begin
         sel_byte = digit_char;
      end else if (pos == TabPos) begin
         sel_byte = AsciiTab;
      end else begin
         sel_byte = head_body.body_bytes[body_off[BodyIdxW-1:0]];
      end
   end

   // Sequencer and output register control.
   always_comb begin
      seq_in = seq_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         seq_in = last ? '0 : seq_ff + 1'b1;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_byte_ff <= sel_byte;
         rsp_run_end_ff <= last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_end = rsp_run_end_ff;

endmodule

`default_nettype wire

FILE: rtl/text_line_number_visible_filter_core.sv
// The first result byte of an input passes through the queue and then the
// output register. The back end's single byte lane gives one output byte per
// cycle while the receiver is ready; a run holds one to eleven bytes at six
// digits. A squeezed newline gives no output; four items queue between.
// Reset is synchronous and active high: it clears the queue, output valid,
// line state, line counter and all configuration registers.
`default_nettype none

module text_line_number_visible_filter_core #(
   parameter int NUMBER_DIGITS = tlnvf_pkg::DefNumberDigits
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [7:0] req_in_byte,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic rsp_run_end,
   input wire logic csr_write_en,
   input wire tlnvf_pkg::csr_index_type csr_index,
   input wire logic [tlnvf_pkg::CsrDataW-1:0] csr_wdata
);
   import tlnvf_pkg::*;

   localparam int DigitsW = 4 * NUMBER_DIGITS;
   localparam int QueueW = DigitsW + $bits(body_type);

   cfg_type cfg_ff;
   logic queue_full;
   logic push;
   body_type push_body;
   logic [DigitsW-1:0] push_digits;
   logic pop;
   logic head_valid;
   logic [QueueW-1:0] head_data;
   body_type head_body;
   logic [DigitsW-1:0] head_digits;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CsrNumberMode: begin
               cfg_ff.number_mode <= csr_wdata[1:0];
            end
            CsrShowTabs: begin
               cfg_ff.tab_caret <= csr_wdata[0];
            end
            CsrShowEnds: begin
               cfg_ff.end_dollar <= csr_wdata[0];
            end
            CsrSqueezeBlank: begin
               cfg_ff.squeeze_blank <= csr_wdata[0];
            end
            CsrShowNonprinting: begin
               cfg_ff.show_nonprinting <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   tlnvf_front #(
      .NUMBER_DIGITS(NUMBER_DIGITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_byte(req_in_byte),
      .queue_full(queue_full),
      .push(push),
      .push_body(push_body),
      .push_digits(push_digits)
   );

   tlnvf_queue #(
      .DATA_WIDTH(QueueW),
      .DEPTH(QueueDepth)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data({push_digits, push_body}),
      .full(queue_full),
      .pop(pop),
      .head_valid(head_valid),
      .head_data(head_data)
   );

   assign head_body = head_data[$bits(body_type)-1:0];
   assign head_digits = head_data[QueueW-1:$bits(body_type)];

   tlnvf_back #(
      .NUMBER_DIGITS(NUMBER_DIGITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_body(head_body),
      .head_digits(head_digits),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_end(rsp_run_end)
   );

endmodule

`default_nettype wire

FILE: rtl/tlnvf_checker.sv
// Port-level checker for the text line filter core, bound to the top level.
// Depends on the assertion macros in the core's defines header.
`default_nettype none
`include "text_line_number_visible_filter_core_defines.svh"

module tlnvf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic rsp_run_end
);

   // A stalled result keeps its byte and end flag.
   `TLNVF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_end), "stalled result changed")

   // A run that is not finished continues in the very next cycle.
   `TLNVF_ASSERT_NEXT(a_run_continues, clock, reset, rsp_valid && rsp_ready && !rsp_run_end, rsp_valid, "gap inside an output run")

   // Reset leaves no result pending and the input side open.
   `TLNVF_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, !rsp_valid && req_ready, "not idle after reset")

endmodule

bind text_line_number_visible_filter_core tlnvf_checker u_checker (.*);

`default_nettype wire

FILE: tb/tb_text_line_number_visible_filter_core.sv
// Self-checking testbench for the text line number and visible character filter core.
// Depends on tlnvf_pkg and text_line_number_visible_filter_core; holds its own predictor.
`timescale 1ns / 100ps

module tb_text_line_number_visible_filter_core;
   import tlnvf_pkg::*;

   localparam int Digits = DefNumberDigits;
   // The line number stops at the largest value the field can show, or at the 20-bit cap if lower.
   localparam longint unsigned FieldMax = longint'(10) ** Digits - 1;
   localparam longint unsigned LineCap = (FieldMax > CountCap) ? CountCap : FieldMax;
   localparam int MaxIdle = 11;
   // Spare idle cycles after the last expected byte has left the block.
   localparam int SettleCycles = 12;
   localparam int PrintLimit = 40;

   typedef struct packed {
      logic [7:0] out_byte;
      logic run_end;
   } rendered_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic rsp_run_end;
   logic csr_write_en = 1'b0;
   csr_index_type csr_index = CsrNumberMode;
   logic [CsrDataW-1:0] csr_wdata = '0;

   // Predictor copy of the settings and line state.
   cfg_type settings = '0;
   logic fresh_line = 1'b1;
   logic blank_kept = 1'b0;
   logic [19:0] shown_line_number = '0;

   rendered_type rendered_due[$];
   int unsigned mismatch_count = 0;
   int unsigned sender_gap_max = MaxIdle;
   int unsigned sink_stall_max = MaxIdle;
   int unsigned sink_hold = 0;

   text_line_number_visible_filter_core #(
      .NUMBER_DIGITS(Digits)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_end(rsp_run_end),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Prints one mismatch line and counts it; the log stays short on a broken build.
   task automatic report_mismatch(input string what);
      if (mismatch_count < PrintLimit) begin
         $display("mismatch at %0t: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   // Works out the rendered run of one accepted byte and queues it.
   function automatic void render_input(input logic [7:0] c);
      logic [7:0] run[$];
      logic [7:0] ch;
      logic [3:0] digit [Digits];
      int unsigned v;
      logic nl;
      logic lead;
      nl = (c == AsciiNewline);
      if (fresh_line) begin
         if (settings.squeeze_blank && nl) begin
            // A blank line after a kept blank line is dropped with no output.
            if (blank_kept) begin
               return;
            end
            blank_kept = 1'b1;
         end else begin
            blank_kept = 1'b0;
         end
         if (settings.number_mode != NumModeNone &&
               (settings.number_mode == NumModeAll || !nl)) begin
            if (shown_line_number < LineCap) begin
               shown_line_number++;
            end
            v = {12'd0, shown_line_number};
            for (int i = Digits - 1; i >= 0; i--) begin
               digit[i] = 4'(v % 10);
               v = v / 10;
            end
            // Leading zeros become spaces, but the last place always shows a digit.
            lead = 1'b1;
            for (int i = 0; i < Digits; i++) begin
               if (lead && i < Digits - 1 && digit[i] == 0) begin
                  run.push_back(AsciiSpace);
               end else begin
                  lead = 1'b0;
                  run.push_back(AsciiZero + 8'(digit[i]));
               end
            end
            run.push_back(AsciiTab);
         end
      end
      if (c == AsciiTab && settings.tab_caret) begin
         run.push_back(AsciiCaret);
         run.push_back(AsciiUpperI);
      end else begin
         if (nl && settings.end_dollar) begin
            run.push_back(AsciiDollar);
         end
         if (settings.show_nonprinting) begin
            ch = c;
            if (ch[7]) begin
               run.push_back(AsciiUpperM);
               run.push_back(AsciiDash);
               ch[7] = 1'b0;
            end
            // Plain tab and newline stay as they are; with the high bit they get a caret.
            if ((ch < CtrlLimit || ch == DelCode) &&
                  (c[7] || (ch != AsciiTab && ch != AsciiNewline))) begin
               run.push_back(AsciiCaret);
               ch = (ch == DelCode) ? DelShown : ch + CaretOffset;
            end
            run.push_back(ch);
         end else begin
            run.push_back(c);
         end
      end
      fresh_line = nl;
      foreach (run[i]) begin
         rendered_due.push_back('{out_byte: run[i], run_end: (i == run.size() - 1)});
      end
   endfunction

   // Sends one byte after a random gap and predicts its run at the transfer.
   task automatic send_byte(input logic [7:0] value);
      int unsigned gap;
      gap = $urandom_range(0, sender_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= value;
      do begin
         @(posedge clock);
      end while (!req_ready);
      render_input(value);
   endtask

   // Waits until every expected byte has come and the block has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rendered_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Writes all five registers in consecutive cycles; called only while idle.
   task automatic load_settings(input logic [1:0] mode, input logic tabs, input logic ends,
         input logic squeeze, input logic visible);
      csr_write_en <= 1'b1;
      csr_index <= CsrNumberMode;
      csr_wdata <= mode;
      @(posedge clock);
      csr_index <= CsrShowTabs;
      csr_wdata <= {1'b0, tabs};
      @(posedge clock);
      csr_index <= CsrShowEnds;
      csr_wdata <= {1'b0, ends};
      @(posedge clock);
      csr_index <= CsrSqueezeBlank;
      csr_wdata <= {1'b0, squeeze};
      @(posedge clock);
      csr_index <= CsrShowNonprinting;
      csr_wdata <= {1'b0, visible};
      @(posedge clock);
      csr_write_en <= 1'b0;
      settings = '{number_mode: mode, tab_caret: tabs, end_dollar: ends,
                   squeeze_blank: squeeze, show_nonprinting: visible};
   endtask

   // Result side: after each transfer the receiver stalls for a drawn number of cycles.
   always @(posedge clock) begin
      int unsigned hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_hold <= 0;
      end else if (rsp_ready && rsp_valid) begin
         hold = $urandom_range(0, sink_stall_max);
         rsp_ready <= (hold == 0);
         sink_hold <= hold;
      end else if (!rsp_ready) begin
         if (sink_hold > 1) begin
            sink_hold <= sink_hold - 1;
         end else begin
            rsp_ready <= 1'b1;
            sink_hold <= 0;
         end
      end
   end

   // Compares each result transfer with the oldest expected byte.
   always @(posedge clock) begin
      rendered_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rendered_due.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %h run_end %b",
                                      rsp_out_byte, rsp_run_end));
         end else begin
            due = rendered_due.pop_front();
            if (rsp_out_byte !== due.out_byte) begin
               report_mismatch($sformatf("out_byte %h, expected %h",
                                         rsp_out_byte, due.out_byte));
            end
            if (rsp_run_end !== due.run_end) begin
               report_mismatch($sformatf("run_end %b, expected %b on byte %h",
                                         rsp_run_end, due.run_end, due.out_byte));
            end
         end
      end
   end

   // Reset settings pass bytes through untouched.
   task automatic test_plain_bytes();
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h41);
      send_byte(AsciiNewline);
   endtask

   // Caret and M- notation, DEL, plain tab and newline, and the dollar before newline.
   task automatic test_visible_notation();
      wait_idle();
      load_settings(NumModeNone, 1'b0, 1'b1, 1'b0, 1'b1);
      send_byte(8'h00);
      send_byte(8'h7f);
      send_byte(8'h80);
      send_byte(8'h89);
      send_byte(8'hff);
      send_byte(AsciiTab);
      send_byte(AsciiNewline);
   endtask

   // Tab shown as a caret pair, while a high tab still takes the M- form.
   task automatic test_tab_marks();
      wait_idle();
      load_settings(NumModeNone, 1'b1, 1'b0, 1'b0, 1'b1);
      send_byte(AsciiTab);
      send_byte(8'h89);
   endtask

   // Numbering of every line with repeated blank lines squeezed out.
   task automatic test_numbered_squeeze();
      wait_idle();
      load_settings(NumModeAll, 1'b0, 1'b0, 1'b1, 1'b0);
      send_byte(AsciiNewline);
      send_byte(AsciiNewline);
      send_byte(AsciiNewline);
      send_byte(8'h41);
      send_byte(AsciiNewline);
   endtask

   // A blank line with squeeze off clears the kept-blank mark; mode three skips blanks.
   task automatic test_squeeze_release();
      wait_idle();
      load_settings(2'd3, 1'b0, 1'b0, 1'b0, 1'b0);
      send_byte(AsciiNewline);
      wait_idle();
      load_settings(2'd2, 1'b0, 1'b0, 1'b1, 1'b0);
      send_byte(AsciiNewline);
      send_byte(AsciiNewline);
      send_byte(8'h7e);
   endtask

   // Random text in phases of changing settings, with runs of blank lines.
   task automatic test_random_text();
      int unsigned burst;
      int unsigned sent;
      logic [7:0] value;
      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         if (phase == 0) begin
            load_settings(NumModeNone, 1'b0, 1'b0, 1'b0, 1'b0);
         end else if (phase == 1) begin
            load_settings(2'd3, 1'b1, 1'b1, 1'b1, 1'b1);
         end else if (phase == 2) begin
            load_settings(NumModeAll, 1'b1, 1'b1, 1'b1, 1'b1);
         end else begin
            load_settings(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
         end
         sender_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MaxIdle;
         sink_stall_max = ($urandom_range(0, 2) == 0) ? 0 : MaxIdle;
         sent = 0;
         while (sent < 29) begin
            if ($urandom_range(0, 9) == 0) begin
               burst = $urandom_range(2, 4);
               repeat (burst) send_byte(AsciiNewline);
               sent += burst;
            end else begin
               case ($urandom_range(0, 19))
                  0, 1, 2, 3: value = AsciiNewline;
                  4: value = AsciiTab;
                  5, 6: value = 8'($urandom_range(0, 31));
                  7: value = 8'h7f;
                  8, 9, 10: value = 8'($urandom_range(128, 255));
                  default: value = 8'($urandom_range(32, 126));
               endcase
               send_byte(value);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_plain_bytes();
      test_visible_notation();
      test_tab_marks();
      test_numbered_squeeze();
      test_squeeze_release();
      test_random_text();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
